// ===== hdl/windowed_extremum_level_detector_core_macros.svh =====
// Assertion macros for the windowed extremum level detector; expect clk and rst_n in scope.
`ifndef WINDOWED_EXTREMUM_LEVEL_DETECTOR_CORE_MACROS_SVH
`define WINDOWED_EXTREMUM_LEVEL_DETECTOR_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define WLD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define WLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wld_pkg.sv =====
// Shared widths, codes and result types of the windowed extremum level detector.
`default_nettype none

package wld_pkg;

  localparam int TimeW   = 64;
  localparam int PriceW  = 32;
  localparam int LenW    = 8;
  localparam int NumSlot = 4;

  localparam logic [LenW-1:0] LenReset = 8'd45;

  // Input item kinds
  localparam logic KindPoint  = 1'b0;
  localparam logic KindLeadIn = 1'b1;

  // Result kinds
  localparam logic LevelMin = 1'b0;
  localparam logic LevelMax = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0]  level_time;
    logic [PriceW-1:0] level_price;
    logic              level_kind;
  } wld_level_t;

  // Up to four results of one transaction, in delivery order (lowest slot first)
  typedef struct packed {
    logic [NumSlot-1:0]              mask;
    wld_level_t [NumSlot-1:0]        slot;
  } wld_burst_t;

endpackage

`default_nettype wire

// ===== hdl/wld_if.sv =====
// Channel interfaces: price input, level output and window length configuration.
`default_nettype none

interface wld_in_if import wld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TimeW-1:0]  point_time;
  logic [PriceW-1:0] point_price;
  logic              end_of_series;

  modport source (output valid, kind, point_time, point_price, end_of_series, input ready);
  modport sink   (input valid, kind, point_time, point_price, end_of_series, output ready);
endinterface

interface wld_out_if import wld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  level_time;
  logic [PriceW-1:0] level_price;
  logic              level_kind;
  logic              last_of_run;

  modport source (output valid, level_time, level_price, level_kind, last_of_run, input ready);
  modport sink   (input valid, level_time, level_price, level_kind, last_of_run, output ready);
endinterface

interface wld_cfg_if import wld_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LenW-1:0] window_length;

  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/windowed_extremum_level_detector_core.sv =====
// Top level of the windowed extremum level detector.
//
// in_ch carries price points (analysed points or lead-in neighbors); a
// transaction is taken when valid and ready are both high. out_ch delivers
// window minimum and maximum levels, with last_of_run on the final level
// caused by one input transaction. cfg_ch writes window_length and is always
// ready; write it only while no results are pending.
// Latency: a level appears on out_ch the cycle after the input transaction
// that decides its window. Throughput: one input per cycle while each input
// yields at most one level and out_ch is ready; an input that yields more
// holds in_ch.ready low until its last level leaves, as the single result
// register drains one level per cycle while out_ch is ready. An input is taken
// in the cycle the last pending level leaves, so receiver stalls hold it too.
// Reset (rst_n low, synchronous) closes any window, forgets the previous
// point, empties the result register and sets window_length to 45.
`default_nettype none

module windowed_extremum_level_detector_core import wld_pkg::*; #(
  parameter int MAX_WINDOW = 255,
  parameter int PRICE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  wld_in_if.sink   in_ch,
  wld_out_if.source out_ch,
  wld_cfg_if.sink  cfg_ch
);

  `include "windowed_extremum_level_detector_core_macros.svh"

  wld_burst_t         res;
  wld_level_t         out_level;
  logic               in_fire, out_fire, free, out_valid, out_last;
  logic [NumSlot-1:0] pend_mask;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = free;
  assign in_fire      = in_ch.valid && free;

  // Track windows and decide levels
  wld_core #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid),
    .cfg_len  (cfg_ch.window_length),
    .in_fire  (in_fire),
    .in_kind  (in_ch.kind),
    .in_time  (in_ch.point_time),
    .in_price (in_ch.point_price),
    .in_eos   (in_ch.end_of_series),
    .res      (res)
  );

  // Register and serialize the results
  wld_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_level (out_level),
    .out_last  (out_last),
    .free      (free),
    .pend_mask (pend_mask)
  );

  assign out_fire           = out_valid && out_ch.ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.level_time  = out_level.level_time;
  assign out_ch.level_price = out_level.level_price;
  assign out_ch.level_kind  = out_level.level_kind;
  assign out_ch.last_of_run = out_last;

  // A lead-in never produces a level, so the register is empty after it is taken
  `WLD_ASSERT_NEXT(a_leadin_quiet, in_fire && (in_ch.kind == KindLeadIn), !out_valid,
                   "lead-in transaction produced a level")

  // Only an end of series can add a second pair of levels
  `WLD_ASSERT_NEXT(a_pair_limit, in_fire && !in_ch.end_of_series,
                   $countones(pend_mask) <= 2, "more than two levels without end of series")

  // After the last level of a run leaves, nothing stays pending unless a new input came
  `WLD_ASSERT_NEXT(a_run_drained, out_fire && out_last && !in_fire, !out_valid,
                   "level pending after last_of_run was delivered")

  // An input is taken only when the result register can be reloaded
  `WLD_ASSERT_SAME(a_load_safe, in_fire, (pend_mask == '0) || (out_fire && out_last),
                   "input taken while levels still pending")

endmodule

`default_nettype wire

// ===== hdl/wld_core.sv =====
// Window tracking state, extremum registers and per-transaction level decisions.
`default_nettype none

module wld_core import wld_pkg::*; #(
  parameter int MAX_WINDOW = 255,
  parameter int PRICE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LenW-1:0]   cfg_len,
  input  logic              in_fire,
  input  logic              in_kind,
  input  logic [TimeW-1:0]  in_time,
  input  logic [PriceW-1:0] in_price,
  input  logic              in_eos,
  output wld_burst_t        res
);

  localparam int PW = (PRICE_BITS < PriceW) ? PRICE_BITS : PriceW;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_WINDOW);

  // Control state
  logic [LenW-1:0] win_len_r;
  logic [LenW-1:0] pos_r, pos_nxt;
  logic            open_r, open_nxt;
  logic [LenW-1:0] min_pos_r, min_pos_nxt;
  logic [LenW-1:0] max_pos_r, max_pos_nxt;
  logic            ln_v_r, ln_v_nxt;
  logic            prev_v_r, prev_v_nxt;

  // Payload state
  logic [PW-1:0]    min_p_r, min_p_nxt;
  logic [TimeW-1:0] min_t_r, min_t_nxt;
  logic [PW-1:0]    max_p_r, max_p_nxt;
  logic [TimeW-1:0] max_t_r, max_t_nxt;
  logic [PW-1:0]    ln_p_r, ln_p_nxt;
  logic [PW-1:0]    prev_p_r, prev_p_nxt;

  logic [PW-1:0]   p;
  logic [LenW-1:0] eff_len;
  logic            is_point, full, fresh;
  logic [LenW-1:0] last1, last2, pos_new;
  logic            lmin1, rmin1, imin1, lmax1, rmax1, imax1;
  logic            min_upd, max_upd;
  logic [LenW-1:0] min_pos_new, max_pos_new;
  logic [PW-1:0]   min_p_new, max_p_new;
  logic [TimeW-1:0] min_t_new, max_t_new;
  logic            ln_v_new;
  logic            lmin2, imin2, lmax2, imax2;

  assign p        = in_price[PW-1:0];
  assign is_point = (in_kind == KindPoint);

  // Clamp the window length to 1..MAX_WINDOW
  always_comb begin
    if (win_len_r == '0) begin
      eff_len = LenW'(1);
    end else if (win_len_r > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = win_len_r;
    end
  end

  // Decide the open window when a full one sees the next point
  assign full  = open_r && (pos_r >= eff_len);
  assign last1 = pos_r - LenW'(1);
  assign lmin1 = (min_pos_r == '0) && ln_v_r && (ln_p_r > min_p_r);
  assign rmin1 = (min_pos_r == last1) && (p > min_p_r);
  assign imin1 = (min_pos_r != '0) && (min_pos_r != last1);
  assign lmax1 = (max_pos_r == '0) && ln_v_r && (ln_p_r < max_p_r);
  assign rmax1 = (max_pos_r == last1) && (p < max_p_r);
  assign imax1 = (max_pos_r != '0) && (max_pos_r != last1);

  // Fold the point into the open window, or start a new one
  assign fresh   = !open_r || full;
  assign min_upd = !fresh && (p < min_p_r);
  assign max_upd = !fresh && (p >= max_p_r);
  assign pos_new = fresh ? LenW'(1) : pos_r + LenW'(1);
  assign last2   = fresh ? '0 : pos_r;

  always_comb begin
    if (fresh) begin
      min_pos_new = '0;
      min_p_new   = p;
      min_t_new   = in_time;
      max_pos_new = '0;
      max_p_new   = p;
      max_t_new   = in_time;
    end else begin
      min_pos_new = min_upd ? pos_r : min_pos_r;
      min_p_new   = min_upd ? p : min_p_r;
      min_t_new   = min_upd ? in_time : min_t_r;
      max_pos_new = max_upd ? pos_r : max_pos_r;
      max_p_new   = max_upd ? p : max_p_r;
      max_t_new   = max_upd ? in_time : max_t_r;
    end
  end

  assign ln_v_new = fresh ? prev_v_r : ln_v_r;

  // End of series: decide the window just updated; no right neighbor exists.
  // A left-edge extremum is either the fresh point or an unchanged old one.
  assign lmin2 = (min_pos_new == '0) && ln_v_new &&
                 (fresh ? (prev_p_r > p) : (ln_p_r > min_p_r));
  assign lmax2 = (max_pos_new == '0) && ln_v_new &&
                 (fresh ? (prev_p_r < p) : (ln_p_r < max_p_r));
  assign imin2 = (min_pos_new != '0) && (min_pos_new != last2);
  assign imax2 = (max_pos_new != '0) && (max_pos_new != last2);

  // Assemble the results of this transaction
  always_comb begin
    res.mask[0] = is_point && full && (lmin1 || rmin1 || imin1);
    res.mask[1] = is_point && full && (lmax1 || rmax1 || imax1);
    res.mask[2] = is_point && in_eos && (lmin2 || imin2);
    res.mask[3] = is_point && in_eos && (lmax2 || imax2);
    res.slot[0] = '{level_time: min_t_r, level_price: PriceW'(min_p_r), level_kind: LevelMin};
    res.slot[1] = '{level_time: max_t_r, level_price: PriceW'(max_p_r), level_kind: LevelMax};
    res.slot[2] = '{level_time: min_t_new, level_price: PriceW'(min_p_new),
                    level_kind: LevelMin};
    res.slot[3] = '{level_time: max_t_new, level_price: PriceW'(max_p_new),
                    level_kind: LevelMax};
  end

  // Next state
  always_comb begin
    pos_nxt     = pos_r;
    open_nxt    = open_r;
    min_pos_nxt = min_pos_r;
    max_pos_nxt = max_pos_r;
    ln_v_nxt    = ln_v_r;
    prev_v_nxt  = prev_v_r;
    min_p_nxt   = min_p_r;
    min_t_nxt   = min_t_r;
    max_p_nxt   = max_p_r;
    max_t_nxt   = max_t_r;
    ln_p_nxt    = ln_p_r;
    prev_p_nxt  = prev_p_r;
    if (in_fire) begin
      if (is_point) begin
        min_pos_nxt = min_pos_new;
        max_pos_nxt = max_pos_new;
        min_p_nxt   = min_p_new;
        min_t_nxt   = min_t_new;
        max_p_nxt   = max_p_new;
        max_t_nxt   = max_t_new;
        ln_v_nxt    = ln_v_new;
        ln_p_nxt    = fresh ? prev_p_r : ln_p_r;
        prev_p_nxt  = p;
        open_nxt    = !in_eos;
        pos_nxt     = in_eos ? '0 : pos_new;
        prev_v_nxt  = !in_eos;
      end else if (!open_r) begin
        prev_p_nxt = p;
        prev_v_nxt = 1'b1;
      end
    end
  end

  // Hold control state and the configured length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= LenReset;
      pos_r     <= '0;
      open_r    <= 1'b0;
      min_pos_r <= '0;
      max_pos_r <= '0;
      ln_v_r    <= 1'b0;
      prev_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_len_r <= cfg_len;
      end
      pos_r     <= pos_nxt;
      open_r    <= open_nxt;
      min_pos_r <= min_pos_nxt;
      max_pos_r <= max_pos_nxt;
      ln_v_r    <= ln_v_nxt;
      prev_v_r  <= prev_v_nxt;
    end
  end

  // Hold prices and timestamps
  always_ff @(posedge clk) begin
    min_p_r  <= min_p_nxt;
    min_t_r  <= min_t_nxt;
    max_p_r  <= max_p_nxt;
    max_t_r  <= max_t_nxt;
    ln_p_r   <= ln_p_nxt;
    prev_p_r <= prev_p_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/wld_burst.sv =====
// Result register: holds the levels of one transaction and hands them out one per cycle while out_ready is high.
`default_nettype none

module wld_burst import wld_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  wld_burst_t         res,
  input  logic               out_ready,
  output logic               out_valid,
  output wld_level_t         out_level,
  output logic               out_last,
  output logic               free,
  output logic [NumSlot-1:0] pend_mask
);

  logic [NumSlot-1:0] mask_r, mask_nxt;
  wld_level_t [NumSlot-1:0] slot_r;
  logic [NumSlot-1:0] sel, remain;
  logic               out_fire;

  // Pick the lowest pending slot
  assign sel       = mask_r & (~mask_r + NumSlot'(1));
  assign out_valid = |mask_r;
  assign out_last  = ((mask_r & (mask_r - NumSlot'(1))) == '0);
  assign out_fire  = out_valid && out_ready;
  assign remain    = out_fire ? (mask_r & ~sel) : mask_r;
  assign free      = (remain == '0);
  assign pend_mask = mask_r;

  always_comb begin
    priority if (mask_r[0]) begin
      out_level = slot_r[0];
    end else if (mask_r[1]) begin
      out_level = slot_r[1];
    end else if (mask_r[2]) begin
      out_level = slot_r[2];
    end else begin
      out_level = slot_r[3];
    end
  end

  // Drop delivered slots, take a new set on load (the top loads once none remain)
  assign mask_nxt = load ? res.mask : remain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= res.slot;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the windowed extremum level detector core.
`timescale 1ns / 1ps

module tb_top;
  import wld_pkg::*;

  localparam int UsePredictor = -1;
  localparam logic RowCfg = 1'b1;
  localparam logic RowItem = 1'b0;
  localparam int HoldCycles = 60;
  localparam int DrainCycles = 4;
  localparam int NumRows = 25;
  localparam int NumPhases = 6;
  localparam longint LimitNs = 64'd5_000_000;
  localparam logic [TimeW-1:0] TimeTop = '1;
  localparam logic [PriceW-1:0] PriceTop = '1;

  // Sink idles most, then source idles most, then neither
  localparam int SrcIdlePct [3] = '{33, 73, 0};
  localparam int SnkIdlePct [3] = '{73, 33, 0};
  localparam int PhaseLen [NumPhases] = '{45, 1, 2, 9, 255, 5};
  localparam int PhaseItems [NumPhases] = '{18, 14, 14, 18, 12, 16};

  typedef struct packed {
    logic [TimeW-1:0]  level_time;
    logic [PriceW-1:0] level_price;
    logic              level_kind;
    logic              last_of_run;
  } level_rec_t;

  typedef struct {
    logic              is_cfg;
    logic [LenW-1:0]   len;
    logic              kind;
    logic [TimeW-1:0]  pt;
    logic [PriceW-1:0] pp;
    logic              eos;
    int                n_typed;
    level_rec_t        ty0;
    level_rec_t        ty1;
  } script_row_t;

  localparam level_rec_t NoLevel = '0;

  logic clk;
  logic rst_n;

  wld_in_if  in_ch ();
  wld_out_if out_ch ();
  wld_cfg_if cfg_ch ();

  windowed_extremum_level_detector_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted detector state
  logic [LenW-1:0]   win_len    = LenReset;
  logic [LenW-1:0]   win_pos    = '0;
  logic              win_open   = 1'b0;
  logic [PriceW-1:0] lo_price   = '0;
  logic [TimeW-1:0]  lo_time    = '0;
  logic [LenW-1:0]   lo_pos     = '0;
  logic [PriceW-1:0] hi_price   = '0;
  logic [TimeW-1:0]  hi_time    = '0;
  logic [LenW-1:0]   hi_pos     = '0;
  logic [PriceW-1:0] left_price = '0;
  logic              left_ok    = 1'b0;
  logic [PriceW-1:0] prev_price = '0;
  logic              prev_ok    = 1'b0;

  level_rec_t levels_due [$];

  // Typed expectations that travel with the item on the input channel
  int         row_typed_n;
  level_rec_t row_typed [2];

  int src_idle = 0;
  int snk_idle = 0;
  logic hold_tog = 1'b0;

  int mismatch_cnt = 0;
  int items_in = 0;
  int leadins_in = 0;
  int series_ends = 0;
  int levels_out = 0;
  int lows_out = 0;
  int highs_out = 0;
  int burst_max = 0;
  int len_writes = 0;

  logic [TimeW-1:0] stamp = 64'd1_600_000_000;

  script_row_t script [NumRows] = '{
    '{RowCfg, 8'd3, KindPoint, '0, '0, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindLeadIn, 64'd1, 32'd500, 1'b0, 0, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd0, 32'd400, 1'b0, 0, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, TimeTop, 32'd0, 1'b0, 0, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd12, PriceTop, 1'b0, 0, NoLevel, NoLevel},
    // interior minimum, right-edge maximum above a lower follower
    '{RowItem, '0, KindPoint, 64'd13, 32'd100, 1'b0, 2,
      '{TimeTop, 32'd0, LevelMin, 1'b0}, '{64'd12, PriceTop, LevelMax, 1'b1}},
    // lead-in inside an open window, end flag on it ignored
    '{RowItem, '0, KindLeadIn, 64'd2, 32'd7, 1'b1, 0, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd14, 32'd100, 1'b0, 0, NoLevel, NoLevel},
    // last of equal maxima kept, minimum at right edge with no follower dropped
    '{RowItem, '0, KindPoint, 64'd15, 32'd50, 1'b1, 1,
      '{64'd14, 32'd100, LevelMax, 1'b1}, NoLevel},
    // fresh series, single point, no neighbors
    '{RowItem, '0, KindPoint, 64'd20, 32'd7, 1'b1, 0, NoLevel, NoLevel},
    '{RowCfg, 8'd0, KindPoint, '0, '0, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindLeadIn, 64'd30, 32'd300, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd31, 32'd200, 1'b0, 0, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd32, 32'd100, 1'b1, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd33, 32'd5, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd34, 32'd5, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd35, 32'd9, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowCfg, 8'd255, KindPoint, '0, '0, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd40, 32'd10, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd41, 32'd3, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd42, 32'd8, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd43, 32'd6, 1'b0, UsePredictor, NoLevel, NoLevel},
    // shrink the open window below its fill level
    '{RowCfg, 8'd2, KindPoint, '0, '0, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd44, 32'd1, 1'b0, UsePredictor, NoLevel, NoLevel},
    '{RowItem, '0, KindPoint, 64'd45, 32'd4, 1'b1, UsePredictor, NoLevel, NoLevel}
  };

  // Close the open window and queue the levels it reports
  function automatic void decide_window(input logic rv, input logic [PriceW-1:0] rp,
                                        ref level_rec_t res [$]);
    logic [LenW-1:0] last;
    logic show_lo;
    logic show_hi;
    level_rec_t rec;
    last = (win_pos == '0) ? '0 : win_pos - 1'b1;
    show_lo = (lo_pos == '0 && left_ok && left_price > lo_price) ||
              (lo_pos == last && rv && rp > lo_price) ||
              (lo_pos != '0 && lo_pos != last);
    show_hi = (hi_pos == '0 && left_ok && left_price < hi_price) ||
              (hi_pos == last && rv && rp < hi_price) ||
              (hi_pos != '0 && hi_pos != last);
    if (show_lo) begin
      rec = '{lo_time, lo_price, LevelMin, 1'b0};
      res.insert(res.size(), rec);
    end
    if (show_hi) begin
      rec = '{hi_time, hi_price, LevelMax, 1'b0};
      res.insert(res.size(), rec);
    end
    win_open = 1'b0;
    win_pos = '0;
  endfunction

  // Advance the predicted state by one accepted item
  function automatic void predict_levels(input logic kind, input logic [TimeW-1:0] t,
                                         input logic [PriceW-1:0] p, input logic eos,
                                         ref level_rec_t res [$]);
    logic [LenW-1:0] eff;
    eff = (win_len == '0) ? 8'd1 : win_len;
    if (kind == KindLeadIn) begin
      if (!win_open) begin
        prev_price = p;
        prev_ok = 1'b1;
      end
      return;
    end
    if (win_open && win_pos >= eff) decide_window(1'b1, p, res);
    if (!win_open) begin
      win_open = 1'b1;
      win_pos = '0;
      left_price = prev_price;
      left_ok = prev_ok;
    end
    if (win_pos == '0) begin
      lo_price = p; lo_time = t; lo_pos = '0;
      hi_price = p; hi_time = t; hi_pos = '0;
    end else begin
      if (p < lo_price) begin
        lo_price = p; lo_time = t; lo_pos = win_pos;
      end
      if (p >= hi_price) begin
        hi_price = p; hi_time = t; hi_pos = win_pos;
      end
    end
    win_pos = win_pos + 1'b1;
    prev_price = p;
    prev_ok = 1'b1;
    if (eos) begin
      decide_window(1'b0, '0, res);
      prev_ok = 1'b0;
      prev_price = '0;
    end
    if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #(LimitNs);
    $display("%0t timeout with %0d levels still due", $time, levels_due.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Result sink: random back-pressure plus a single long hold-off
  initial begin : level_sink
    int hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // Check delivered levels, track the length register, predict on each input transaction
  always @(posedge clk) begin : level_check
    level_rec_t got;
    level_rec_t want;
    level_rec_t fresh [$];
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.level_time, out_ch.level_price, out_ch.level_kind, out_ch.last_of_run};
        levels_out++;
        if (got.level_kind == LevelMin) lows_out++;
        else highs_out++;
        if (levels_due.size() == 0) begin
          mismatch_cnt++;
          $display("%0t unexpected level: time %h price %h kind %b last %b", $time,
                   got.level_time, got.level_price, got.level_kind, got.last_of_run);
        end else begin
          want = levels_due.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            $display("%0t level mismatch: expected time %h price %h kind %b last %b",
                     $time, want.level_time, want.level_price, want.level_kind,
                     want.last_of_run);
            $display("%0t                 actual   time %h price %h kind %b last %b",
                     $time, got.level_time, got.level_price, got.level_kind,
                     got.last_of_run);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        win_len = cfg_ch.window_length;
        len_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        fresh.delete();
        predict_levels(in_ch.kind, in_ch.point_time, in_ch.point_price, in_ch.end_of_series,
                       fresh);
        if (in_ch.kind == KindLeadIn) leadins_in++;
        else items_in++;
        if (in_ch.kind == KindPoint && in_ch.end_of_series) series_ends++;
        if (fresh.size() > burst_max) burst_max = fresh.size();
        if (row_typed_n == UsePredictor) begin
          foreach (fresh[i]) levels_due.insert(levels_due.size(), fresh[i]);
        end else begin
          for (int i = 0; i < row_typed_n; i++) levels_due.insert(levels_due.size(), row_typed[i]);
        end
      end
    end
  end

  // Offer one item after a random gap and hold it until the transaction
  task automatic send_item(input logic kind, input logic [TimeW-1:0] t,
                           input logic [PriceW-1:0] p, input logic eos,
                           input int n_typed, input level_rec_t ty0, input level_rec_t ty1);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.point_time <= t;
    in_ch.point_price <= p;
    in_ch.end_of_series <= eos;
    row_typed_n <= n_typed;
    row_typed[0] <= ty0;
    row_typed[1] <= ty1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, let the last transaction be predicted, then let every due level drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (levels_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_len(input logic [LenW-1:0] len);
    cfg_ch.valid <= 1'b1;
    cfg_ch.window_length <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [PriceW-1:0] pick_price();
    case ($urandom_range(7))
      0: return '0;
      1: return PriceTop;
      2: return $urandom;
      default: return 32'd10000 + $urandom_range(6);
    endcase
  endfunction

  // Mostly increasing timestamps, sometimes any 64-bit value
  function automatic logic [TimeW-1:0] pick_time();
    if ($urandom_range(9) < 3) return {$urandom, $urandom};
    stamp = stamp + 64'($urandom_range(1, 86400));
    return stamp;
  endfunction

  // Random series: optional lead-in, a run of points, usually closed by the end flag
  task automatic run_phase(input int len, input int n_items);
    int sent;
    int span;
    int eff;
    logic close;
    sent = 0;
    eff = (len == 0) ? 1 : len;
    while (sent < n_items) begin
      span = $urandom_range(1, (eff > 8 ? 8 : eff) * 2 + 3);
      if (span > n_items - sent) span = n_items - sent;
      if ($urandom_range(3) != 0)
        send_item(KindLeadIn, pick_time(), pick_price(), 1'($urandom_range(1)), UsePredictor,
                  NoLevel, NoLevel);
      for (int i = 0; i < span; i++) begin
        if ($urandom_range(19) == 0)
          send_item(KindLeadIn, pick_time(), pick_price(), 1'($urandom_range(1)),
                    UsePredictor, NoLevel, NoLevel);
        close = (i == span - 1) && ($urandom_range(4) != 0);
        send_item(KindPoint, pick_time(), pick_price(), close, UsePredictor, NoLevel,
                  NoLevel);
        sent++;
      end
    end
  endtask

  // Stimulus sequence
  initial begin : stimulus
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KindPoint;
    in_ch.point_time <= '0;
    in_ch.point_price <= '0;
    in_ch.end_of_series <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.window_length <= LenReset;
    row_typed_n <= UsePredictor;
    row_typed[0] <= NoLevel;
    row_typed[1] <= NoLevel;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    src_idle = SrcIdlePct[0];
    snk_idle = SnkIdlePct[0];
    foreach (script[r]) begin
      if (script[r].is_cfg == RowCfg) begin
        wait_idle();
        write_len(script[r].len);
      end else begin
        send_item(script[r].kind, script[r].pt, script[r].pp, script[r].eos,
                  script[r].n_typed, script[r].ty0, script[r].ty1);
      end
    end

    // Random phases over several window lengths
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      write_len(PhaseLen[ph]);
      src_idle = SrcIdlePct[ph / 2];
      snk_idle = SnkIdlePct[ph / 2];
      if (ph == 1) hold_tog = ~hold_tog;
      run_phase(PhaseLen[ph], PhaseItems[ph]);
    end

    wait_idle();

    $display("Covered %0d points, %0d lead-ins, %0d series ends, %0d length writes",
             items_in, leadins_in, series_ends, len_writes);
    $display("Checked %0d levels (%0d minima, %0d maxima), up to %0d from one point",
             levels_out, lows_out, highs_out, burst_max);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
